/* sv/pva_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_pkg
// Shared constants, tables and types of the polar vector accumulator.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int CORDIC_ITERATIONS = 20;
    localparam int SUM_BITS          = 32;
    localparam int GUARD             = 8;

    // datapath widths
    localparam int DP_W    = SUM_BITS + GUARD + 3;
    localparam int VEC_W   = DP_W - GUARD;
    localparam int ACC_W   = VEC_W + 1;
    localparam int ANG_W   = 34;
    localparam int ITER_W  = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
    localparam int HI_W    = DP_W - 1 - 30;
    localparam int MAG_W   = SUM_BITS + 11;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 30;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int FRAC_W  = 23;
    localparam int Q_W     = 11;
    localparam int ATAN_N  = 32;
    localparam int ATAN_IDX_W = 5;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

    localparam logic [15:0]        FULL_CIRCLE   = 16'd23040;
    localparam logic [29:0]        INV_GAIN_Q30  = 30'd652032874;
    localparam logic [15:0]        RECIP45       = 16'd46604;
    localparam int                 RECIP45_SHIFT = 21;
    localparam logic [15:0]        TURN_DIV      = 16'd45;
    localparam logic [PROD_W-1:0]  HALF_Q30      = PROD_W'(64'd1 << 29);
    localparam logic [PROD_W-1:0]  HALF_Q32      = PROD_W'(64'd1 << 31);

    localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(64'd1 << 30);
    localparam logic signed [ANG_W-1:0] ANG_HALF    = ANG_W'(64'd1 << 31);

    localparam logic [0:0] OP_START = 1'b0;
    localparam logic [0:0] OP_ADD   = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SKIPPED  = 2'd1;
    localparam logic [1:0] STATUS_NO_START = 2'd2;

    // arctangent of 2^-i in 2^32 per turn
    localparam logic [29:0] ATAN_TURNS [ATAN_N] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
        30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
        30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
        30'd20,        30'd10,        30'd5,         30'd3,        30'd1,
        30'd1,         30'd0
    };

    // fractional turn of a bearing remainder r (0..44): round(r * 2^32 / 23040) low bits
    typedef logic [FRAC_W-1:0] t_frac_tab [45];

    function automatic t_frac_tab f_build_frac();
        t_frac_tab tab;
        for (int i = 0; i < 45; i++) begin
            tab[i] = FRAC_W'(((64'(i) << 23) + 64'd22) / 64'd45);
        end
        return tab;
    endfunction

    localparam t_frac_tab TURN_FRAC = f_build_frac();

    typedef logic signed [DP_W-1:0]  t_dp;
    typedef logic signed [ANG_W-1:0] t_ang;

    typedef enum logic [1:0] {
        MUL_RECIP45,
        MUL_INV_GAIN,
        MUL_BEARING
    } t_mul_sel;

    typedef struct packed {
        logic                en;
        t_mul_sel            sel;
        logic [MUL_A_W-1:0]  a;
    } t_mul_req;

    typedef struct packed {
        logic              load;
        logic              step;
        logic              rotate;
        logic [ITER_W-1:0] iter;
    } t_cordic_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_Q,
        S_MUL_S,
        S_ROT_LOAD,
        S_ROT,
        S_ROT_END,
        S_VEC_LOAD,
        S_VEC,
        S_MAG_LO,
        S_MAG_HI,
        S_BEAR,
        S_BEAR_END,
        S_DONE
    } t_state;

endpackage

/* sv/pva_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_in_if
// Input vector channel: opcode, bearing and strength with valid/ready.
// ----------------------------------------------------------------------------
interface pva_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  opcode;
    logic [15:0] bearing;
    logic [23:0] strength;

    modport source (output valid, output opcode, output bearing, output strength,
                    input ready);
    modport sink   (input valid, input opcode, input bearing, input strength,
                    output ready);
endinterface

/* sv/pva_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_out_if
// Resultant channel: bearing, strength and status with valid/ready.
// ----------------------------------------------------------------------------
interface pva_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] total_bearing;
    logic [23:0] total_strength;
    logic [1:0]  status;

    modport source (output valid, output total_bearing, output total_strength,
                    output status, input ready);
    modport sink   (input valid, input total_bearing, input total_strength,
                    input status, output ready);
endinterface

/* sv/pva_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_cfg_if
// Configuration write channel carrying the strength clamp register.
// ----------------------------------------------------------------------------
interface pva_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] max_strength;

    modport source (output valid, output max_strength, input ready);
    modport sink   (input valid, input max_strength, output ready);
endinterface

/* sv/pva_mult.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_mult
// Shared multiplier by a selected constant, product registered.
// ----------------------------------------------------------------------------
module pva_mult (
    input  logic                          i_clk,
    input  pva_pkg::t_mul_req             i_req,
    output logic [pva_pkg::PROD_W-1:0]    o_prod
);
    import pva_pkg::*;

    logic [PROD_W-1:0]  r_prod;
    logic [MUL_B_W-1:0] coef;

    always_comb begin
        unique case (i_req.sel)
            MUL_RECIP45:  coef = MUL_B_W'(RECIP45);
            MUL_INV_GAIN: coef = INV_GAIN_Q30;
            MUL_BEARING:  coef = MUL_B_W'(FULL_CIRCLE);
            default:      coef = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= PROD_W'(i_req.a) * PROD_W'(coef);
        end
    end

    assign o_prod = r_prod;

endmodule

/* sv/pva_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_cordic
// CORDIC x/y/z registers with one micro-rotation per step, rotation or
// vectoring direction rule.
// ----------------------------------------------------------------------------
module pva_cordic (
    input  logic                  i_clk,
    input  pva_pkg::t_cordic_ctl  i_ctl,
    input  pva_pkg::t_dp          i_x,
    input  pva_pkg::t_dp          i_y,
    input  pva_pkg::t_ang         i_z,
    output pva_pkg::t_dp          o_x,
    output pva_pkg::t_dp          o_y,
    output pva_pkg::t_ang         o_z
);
    import pva_pkg::*;

    t_dp  r_x, r_y;
    t_ang r_z;
    t_dp  dx, dy;
    t_ang da;
    logic ccw;
    logic [ATAN_IDX_W-1:0] atan_idx;

    always_comb begin
        atan_idx = ATAN_IDX_W'(i_ctl.iter);
        dx       = r_y >>> i_ctl.iter;
        dy       = r_x >>> i_ctl.iter;
        da       = t_ang'({{(ANG_W - 30){1'b0}}, ATAN_TURNS[atan_idx]});
        // rotation drives z to zero, vectoring drives y to zero
        if (i_ctl.rotate) begin
            ccw = ~r_z[ANG_W-1];
        end else begin
            ccw = r_y[DP_W-1] || (r_y == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end else if (i_ctl.step) begin
            if (ccw) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - da;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + da;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

/* sv/polar_vector_accumulator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_vector_accumulator_top
// Running sum of polar vectors with resultant bearing and clamped strength.
// ----------------------------------------------------------------------------
// One vector at a time. A valid vector is rotated to x/y, added to the running
// sum and vectored back to bearing and strength; the block is ready for the next
// vector in the same cycle that its result appears on the output. An invalid
// influence skips the rotation pass, and a refused or unstarted item goes
// straight to the output. A zero resultant skips the vectoring pass and its
// final multiplies. The single CORDIC stage runs the rotation pass (polar to
// x/y) and then the vectoring pass (x/y to bearing and magnitude) one
// micro-rotation per cycle, with the shared constant multiplier used before and
// after the passes. The block takes a new vector while a finished result still
// waits on the output; the next finished result then waits until the output
// register is free.
// ----------------------------------------------------------------------------
module polar_vector_accumulator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pva_in_if.sink     i_in,
    pva_out_if.source  o_out,
    pva_cfg_if.sink    i_cfg
);
    import pva_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_SUM_MAX =
        {{(ACC_W - SUM_BITS + 1){1'b0}}, {(SUM_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_SUM_MIN =
        {{(ACC_W - SUM_BITS + 1){1'b1}}, {(SUM_BITS - 1){1'b0}}};
    localparam t_dp GUARD_HALF = t_dp'(64'd1 << (GUARD - 1));

    t_state r_state, n_state;

    logic signed [SUM_BITS-1:0] r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic        r_started, n_started;
    logic [23:0] r_max_strength, n_max_strength;
    logic        r_out_valid, n_out_valid;

    logic [0:0]        r_op, n_op;
    logic [15:0]       r_bearing, n_bearing;
    logic [23:0]       r_strength, n_strength;
    logic [31:0]       r_turn, n_turn;
    logic              r_flip, n_flip;
    logic [1:0]        r_status, n_status;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [30:0]       r_mag_lo, n_mag_lo;
    logic [14:0]       r_res_bearing, n_res_bearing;
    logic [23:0]       r_res_strength, n_res_strength;
    logic [14:0]       r_out_bearing, n_out_bearing;
    logic [23:0]       r_out_strength, n_out_strength;
    logic [1:0]        r_out_status, n_out_status;

    t_mul_req          mul_req;
    logic [PROD_W-1:0] prod;
    t_cordic_ctl       cctl;
    t_dp               ld_x, ld_y, cx, cy;
    t_ang              ld_z, cz;

    // combinational helpers
    logic              in_take;
    logic              bearing_ok;
    logic [Q_W-1:0]    quot;
    logic [15:0]       rem16;
    logic [5:0]        rem;
    logic [PROD_W-1:0] rnd_sum;
    logic [PROD_W-1:0] bear_sum;
    t_ang              zs;
    t_dp               xf, yf, xr, yr;
    logic signed [VEC_W-1:0]    vx, vy;
    logic signed [SUM_BITS-1:0] bx, by;
    logic signed [ACC_W-1:0]    ax, ay;
    t_dp               sx, sy;
    logic [DP_W-2:0]   ux;
    logic [MAG_W-1:0]  mag_sum;
    logic [MAG_W-GUARD-1:0] mag_rnd;
    logic [14:0]       bear;

    pva_mult u_mult (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    pva_cordic u_cordic (
        .i_clk (i_clk),
        .i_ctl (cctl),
        .i_x   (ld_x),
        .i_y   (ld_y),
        .i_z   (ld_z),
        .o_x   (cx),
        .o_y   (cy),
        .o_z   (cz)
    );

    assign i_in.ready          = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.total_bearing = r_out_bearing;
    assign o_out.total_strength = r_out_strength;
    assign o_out.status        = r_out_status;

    always_comb begin
        in_take    = i_in.valid && (r_state == S_IDLE);
        bearing_ok = (i_in.bearing <= FULL_CIRCLE);

        // bearing to turn: q = bearing / 45, then table on the remainder
        quot  = prod[RECIP45_SHIFT +: Q_W];
        rem16 = r_bearing - 16'(16'(quot) * TURN_DIV);
        rem   = rem16[5:0];

        rnd_sum  = prod + HALF_Q30;
        bear_sum = prod + HALF_Q32;

        zs = t_ang'({{(ANG_W - 32){r_turn[31]}}, r_turn});

        // end of rotation pass: undo the half-turn fold, drop guard bits
        xf = r_flip ? -cx : cx;
        yf = r_flip ? -cy : cy;
        xr = xf + GUARD_HALF;
        yr = yf + GUARD_HALF;
        vx = xr[DP_W-1:GUARD];
        vy = yr[DP_W-1:GUARD];
        bx = (r_op == OP_START) ? '0 : r_sum_x;
        by = (r_op == OP_START) ? '0 : r_sum_y;
        ax = ACC_W'(bx) + ACC_W'(vx);
        ay = ACC_W'(by) + ACC_W'(vy);

        sx = t_dp'(r_sum_x) <<< GUARD;
        sy = t_dp'(r_sum_y) <<< GUARD;

        ux = (cx[DP_W-1] || (cx == '0)) ? '0 : cx[DP_W-2:0];

        mag_sum = MAG_W'(prod) + MAG_W'(r_mag_lo) + MAG_W'(GUARD_HALF);
        mag_rnd = mag_sum[MAG_W-1:GUARD];

        bear = bear_sum[32 +: 15];
    end

    always_comb begin
        n_state        = r_state;
        n_sum_x        = r_sum_x;
        n_sum_y        = r_sum_y;
        n_started      = r_started;
        n_max_strength = r_max_strength;
        n_out_valid    = r_out_valid;
        n_op           = r_op;
        n_bearing      = r_bearing;
        n_strength     = r_strength;
        n_turn         = r_turn;
        n_flip         = r_flip;
        n_status       = r_status;
        n_iter         = r_iter;
        n_mag_lo       = r_mag_lo;
        n_res_bearing  = r_res_bearing;
        n_res_strength = r_res_strength;
        n_out_bearing  = r_out_bearing;
        n_out_strength = r_out_strength;
        n_out_status   = r_out_status;

        mul_req     = '{en: 1'b0, sel: MUL_RECIP45, a: '0};
        cctl        = '{load: 1'b0, step: 1'b0, rotate: 1'b1, iter: r_iter};
        ld_x        = '0;
        ld_y        = '0;
        ld_z        = '0;

        if (i_cfg.valid) begin
            n_max_strength = i_cfg.max_strength;
        end

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_op           = i_in.opcode;
                    n_bearing      = i_in.bearing;
                    n_strength     = i_in.strength;
                    n_res_bearing  = '0;
                    n_res_strength = '0;
                    if (i_in.opcode == OP_START) begin
                        if (bearing_ok) begin
                            n_status = STATUS_OK;
                            n_state  = S_MUL_Q;
                        end else begin
                            // refused start vector drops the running sum
                            n_status  = STATUS_NO_START;
                            n_started = 1'b0;
                            n_sum_x   = '0;
                            n_sum_y   = '0;
                            n_state   = S_DONE;
                        end
                    end else if (!r_started) begin
                        n_status = STATUS_NO_START;
                        n_state  = S_DONE;
                    end else if (!bearing_ok) begin
                        n_status = STATUS_SKIPPED;
                        n_state  = S_VEC_LOAD;
                    end else begin
                        n_status = STATUS_OK;
                        n_state  = S_MUL_Q;
                    end
                end
            end
            S_MUL_Q: begin
                mul_req = '{en: 1'b1, sel: MUL_RECIP45, a: MUL_A_W'(r_bearing)};
                n_state = S_MUL_S;
            end
            S_MUL_S: begin
                n_turn  = {quot[8:0], TURN_FRAC[rem]};
                mul_req = '{en: 1'b1, sel: MUL_INV_GAIN, a: MUL_A_W'(r_strength)};
                n_state = S_ROT_LOAD;
            end
            S_ROT_LOAD: begin
                cctl.load = 1'b1;
                ld_x      = t_dp'({rnd_sum[30 +: 24], {GUARD{1'b0}}});
                ld_y      = '0;
                // fold into the right half plane, flip the result afterward
                if (zs > ANG_QUARTER) begin
                    ld_z   = zs - ANG_HALF;
                    n_flip = 1'b1;
                end else if (zs < -ANG_QUARTER) begin
                    ld_z   = zs + ANG_HALF;
                    n_flip = 1'b1;
                end else begin
                    ld_z   = zs;
                    n_flip = 1'b0;
                end
                n_iter  = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                cctl.step = 1'b1;
                if (r_iter == ITER_LAST) begin
                    n_state = S_ROT_END;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_ROT_END: begin
                if (ax > ACC_SUM_MAX) begin
                    n_sum_x = ACC_SUM_MAX[SUM_BITS-1:0];
                end else if (ax < ACC_SUM_MIN) begin
                    n_sum_x = ACC_SUM_MIN[SUM_BITS-1:0];
                end else begin
                    n_sum_x = ax[SUM_BITS-1:0];
                end
                if (ay > ACC_SUM_MAX) begin
                    n_sum_y = ACC_SUM_MAX[SUM_BITS-1:0];
                end else if (ay < ACC_SUM_MIN) begin
                    n_sum_y = ACC_SUM_MIN[SUM_BITS-1:0];
                end else begin
                    n_sum_y = ay[SUM_BITS-1:0];
                end
                n_started = 1'b1;
                n_state   = S_VEC_LOAD;
            end
            S_VEC_LOAD: begin
                if ((r_sum_x == '0) && (r_sum_y == '0)) begin
                    n_res_bearing  = '0;
                    n_res_strength = '0;
                    n_state        = S_DONE;
                end else begin
                    cctl.load = 1'b1;
                    // left half plane: turn by half a turn first
                    if (r_sum_x[SUM_BITS-1]) begin
                        ld_x = -sx;
                        ld_y = -sy;
                        ld_z = ANG_HALF;
                    end else begin
                        ld_x = sx;
                        ld_y = sy;
                        ld_z = '0;
                    end
                    n_iter  = '0;
                    n_state = S_VEC;
                end
            end
            S_VEC: begin
                cctl.step   = 1'b1;
                cctl.rotate = 1'b0;
                if (r_iter == ITER_LAST) begin
                    n_state = S_MAG_LO;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_MAG_LO: begin
                mul_req = '{en: 1'b1, sel: MUL_INV_GAIN, a: MUL_A_W'(ux[29:0])};
                n_state = S_MAG_HI;
            end
            S_MAG_HI: begin
                n_mag_lo = rnd_sum[30 +: 31];
                mul_req  = '{en: 1'b1, sel: MUL_INV_GAIN, a: MUL_A_W'(ux[DP_W-2:30])};
                n_state  = S_BEAR;
            end
            S_BEAR: begin
                if (mag_rnd > (MAG_W - GUARD)'(r_max_strength)) begin
                    n_res_strength = r_max_strength;
                end else begin
                    n_res_strength = mag_rnd[23:0];
                end
                mul_req = '{en: 1'b1, sel: MUL_BEARING, a: cz[31:0]};
                n_state = S_BEAR_END;
            end
            S_BEAR_END: begin
                n_res_bearing = (16'(bear) >= FULL_CIRCLE) ? '0 : bear;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid    = 1'b1;
                    n_out_bearing  = r_res_bearing;
                    n_out_strength = r_res_strength;
                    n_out_status   = r_status;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sum_x        <= '0;
            r_sum_y        <= '0;
            r_started      <= 1'b0;
            r_max_strength <= 24'hFFFFFF;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_sum_x        <= n_sum_x;
            r_sum_y        <= n_sum_y;
            r_started      <= n_started;
            r_max_strength <= n_max_strength;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op           <= n_op;
        r_bearing      <= n_bearing;
        r_strength     <= n_strength;
        r_turn         <= n_turn;
        r_flip         <= n_flip;
        r_status       <= n_status;
        r_iter         <= n_iter;
        r_mag_lo       <= n_mag_lo;
        r_res_bearing  <= n_res_bearing;
        r_res_strength <= n_res_strength;
        r_out_bearing  <= n_out_bearing;
        r_out_strength <= n_out_strength;
        r_out_status   <= n_out_status;
    end

    // no sum held means both sums read zero
    a_unstarted_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_sum_x == '0) && (r_sum_y == '0))
        else $error("sums nonzero without a started sum");

    a_bearing_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (16'(r_out_bearing) < FULL_CIRCLE))
        else $error("resultant bearing out of range");

    a_no_start_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == STATUS_NO_START)) |->
            (r_out_bearing == '0) && (r_out_strength == '0))
        else $error("refused transaction carries a nonzero resultant");

    a_iter_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ROT) || (r_state == S_VEC)) |-> (r_iter <= ITER_LAST))
        else $error("cordic iteration count overran");

    a_pass_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT_END) |=> (r_state == S_VEC_LOAD) && r_started)
        else $error("rotation pass not followed by vectoring pass");

endmodule
